FILE: hw/rtl/hnsd_pkg.sv
package hnsd_pkg;

	// Store sizes and sample width (ring sizes are powers of two)
	localparam int MAX_SMOOTHING = 16;
	localparam int MAX_DECISION  = 64;
	localparam int SAMPLE_BITS   = 16;

	localparam int SM_IDX_W = $clog2(MAX_SMOOTHING);
	localparam int FL_W     = $clog2(MAX_SMOOTHING + 1);
	localparam int SUM_W    = SAMPLE_BITS + SM_IDX_W;
	localparam int STEP_W   = $clog2(SUM_W + 1);

	localparam int DEC_IDX_W = $clog2(MAX_DECISION);
	localparam int DL_W      = $clog2(MAX_DECISION + 1);
	localparam int CNT_W     = DEC_IDX_W;

	localparam int DECISION_MIN  = 15;
	localparam int SUBWINDOW_MIN = 3;
	localparam int SUBWINDOW_MAX = 16;
	localparam int STRIDE_LESS   = 2;
	localparam int SL_W          = 5;
	localparam int K_W           = $clog2(SUBWINDOW_MAX);

	localparam int MAG_W   = SAMPLE_BITS;
	localparam int HSUM_W  = MAG_W + CNT_W;
	localparam int PROD_W  = HSUM_W + CNT_W;
	localparam int SWING_W = 15;
	localparam int PEAKS_W = 6;
	localparam int CFG_DATA_W = 15;

	typedef enum logic [2:0] {
		CFG_SOURCE_SELECT    = 3'd0,
		CFG_FILTER_LENGTH    = 3'd1,
		CFG_SUBWINDOW_LENGTH = 3'd2,
		CFG_DECISION_LENGTH  = 3'd3,
		CFG_SHAKE_MIN_SWING  = 3'd4,
		CFG_NOD_MIN_SWING    = 3'd5,
		CFG_SHAKE_MIN_PEAKS  = 3'd6,
		CFG_NOD_MIN_PEAKS    = 3'd7
	} cfg_index_t;

	typedef enum logic [1:0] {
		VERDICT_FILL     = 2'd0,
		VERDICT_CONTINUE = 2'd1,
		VERDICT_NOD      = 2'd2,
		VERDICT_SHAKE    = 2'd3
	} verdict_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] h;
		logic signed [SAMPLE_BITS-1:0] v;
	} sample_pair_t;

	typedef struct packed {
		verdict_t             verdict;
		logic [PEAKS_W-1:0]   hpeaks;
		logic [PEAKS_W-1:0]   vpeaks;
	} result_t;

	typedef struct packed {
		logic                 source;
		logic [4:0]           flen;
		logic [4:0]           slen;
		logic [6:0]           dlen;
		logic [SWING_W-1:0]   shake_swing;
		logic [SWING_W-1:0]   nod_swing;
		logic [PEAKS_W-1:0]   shake_peaks;
		logic [PEAKS_W-1:0]   nod_peaks;
	} cfg_t;

	// Window side status seen by the smoothing side
	typedef struct packed {
		logic busy;
		logic clear;
	} back_status_t;

	typedef struct packed {
		logic                          hit;
		logic [MAG_W-1:0]              mag;
		logic signed [SAMPLE_BITS-1:0] value;
	} peak_t;

	function automatic logic [FL_W-1:0] clamp_flen(input logic [4:0] v);
		if (v == 5'd0) return FL_W'(1);
		if (int'(v) > MAX_SMOOTHING) return FL_W'(MAX_SMOOTHING);
		return FL_W'(v);
	endfunction

	function automatic logic [SL_W-1:0] clamp_slen(input logic [4:0] v);
		if (int'(v) < SUBWINDOW_MIN) return SL_W'(SUBWINDOW_MIN);
		if (int'(v) > SUBWINDOW_MAX) return SL_W'(SUBWINDOW_MAX);
		return v;
	endfunction

	function automatic logic [DL_W-1:0] clamp_dlen(input logic [6:0] v);
		if (int'(v) < DECISION_MIN) return DL_W'(DECISION_MIN);
		if (int'(v) > MAX_DECISION) return DL_W'(MAX_DECISION);
		return DL_W'(v);
	endfunction

	// Interior max first, then interior min, against the reference
	function automatic peak_t peak_check(
		input logic signed [SAMPLE_BITS-1:0] maxv,
		input logic signed [SAMPLE_BITS-1:0] minv,
		input logic signed [SAMPLE_BITS-1:0] w0,
		input logic [K_W-1:0]                maxi,
		input logic [K_W-1:0]                mini,
		input logic                          have_last,
		input logic signed [SAMPLE_BITS-1:0] last,
		input logic [SWING_W-1:0]            limit,
		input logic [SL_W-1:0]               n_last
	);
		logic signed [SAMPLE_BITS-1:0] refv;
		logic signed [SAMPLE_BITS:0]   dmax, dmin;
		logic [SAMPLE_BITS:0]          amax, amin;
		peak_t                         r;
		refv = have_last ? last : w0;
		dmax = (SAMPLE_BITS+1)'(maxv) - (SAMPLE_BITS+1)'(refv);
		dmin = (SAMPLE_BITS+1)'(minv) - (SAMPLE_BITS+1)'(refv);
		amax = dmax[SAMPLE_BITS] ? (SAMPLE_BITS+1)'(-dmax) : (SAMPLE_BITS+1)'(dmax);
		amin = dmin[SAMPLE_BITS] ? (SAMPLE_BITS+1)'(-dmin) : (SAMPLE_BITS+1)'(dmin);
		r.hit   = 1'b0;
		r.mag   = '0;
		r.value = refv;
		if (maxi != '0 && SL_W'(maxi) != n_last && int'(amax) >= int'(limit)) begin
			r.hit   = 1'b1;
			r.mag   = MAG_W'(amax);
			r.value = maxv;
		end else if (mini != '0 && SL_W'(mini) != n_last && int'(amin) >= int'(limit)) begin
			r.hit   = 1'b1;
			r.mag   = MAG_W'(amin);
			r.value = minv;
		end
		return r;
	endfunction

endpackage

FILE: hw/rtl/head_nod_shake_detector.sv
// Path, request accepted to result on the ports: request queue, smoothing filter (the
//   sample passes unaveraged while the filter fills, else averaged over filter_length), then
//   the decision window, where a full window adds the scan, drain, multiply and compare steps.
// Throughput: one sample at a time; smoothing of the next sample waits until the window
//   side has pushed its result.
// Reset (arst_n low, asynchronous): queues empty, stores empty, registers at defaults.
module head_nod_shake_detector (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   push,
	output logic                                   full,
	input  logic signed [hnsd_pkg::SAMPLE_BITS-1:0] horizontal_sample,
	input  logic signed [hnsd_pkg::SAMPLE_BITS-1:0] vertical_sample,
	output logic                                   empty,
	input  logic                                   pop,
	output logic [1:0]                             verdict,
	output logic [hnsd_pkg::PEAKS_W-1:0]           horizontal_peaks,
	output logic [hnsd_pkg::PEAKS_W-1:0]           vertical_peaks,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [2:0]                             cfg_index,
	input  logic [hnsd_pkg::CFG_DATA_W-1:0]        cfg_data
);
	import hnsd_pkg::*;

	cfg_t         cfg_q;
	sample_pair_t in_pair, q_pair, sm_pair;
	logic         q_valid, q_pop, sm_valid, win_ready, res_push, out_room;
	back_status_t back;
	result_t      res, out_q [2];
	logic         out_wr_q, out_rd_q;
	logic [1:0]   out_cnt_q;

	assign cfg_ready = 1'b1;
	assign in_pair   = '{h: horizontal_sample, v: vertical_sample};

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{source: 1'b1, flen: 5'd5, slen: 5'd7, dlen: 7'd45,
			           shake_swing: 15'd160, nod_swing: 15'd160,
			           shake_peaks: 6'd3, nod_peaks: 6'd3};
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index_t'(cfg_index))
				CFG_SOURCE_SELECT:    cfg_q.source      <= cfg_data[0];
				CFG_FILTER_LENGTH:    cfg_q.flen        <= cfg_data[4:0];
				CFG_SUBWINDOW_LENGTH: cfg_q.slen        <= cfg_data[4:0];
				CFG_DECISION_LENGTH:  cfg_q.dlen        <= cfg_data[6:0];
				CFG_SHAKE_MIN_SWING:  cfg_q.shake_swing <= cfg_data;
				CFG_NOD_MIN_SWING:    cfg_q.nod_swing   <= cfg_data;
				CFG_SHAKE_MIN_PEAKS:  cfg_q.shake_peaks <= cfg_data[5:0];
				CFG_NOD_MIN_PEAKS:    cfg_q.nod_peaks   <= cfg_data[5:0];
				default: ;
			endcase
		end
	end

	// Front: request queue and smoothing
	hnsd_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (in_pair),
		.full   (full),
		.pop    (q_pop),
		.rdata  (q_pair),
		.valid  (q_valid)
	);

	hnsd_smooth u_smooth (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_pair       (q_pair),
		.in_valid      (q_valid),
		.in_pop        (q_pop),
		.filter_length (cfg_q.flen),
		.back          (back),
		.out_pair      (sm_pair),
		.out_valid     (sm_valid),
		.out_take      (win_ready)
	);

	// Back: decision window and peak scan
	hnsd_window u_window (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_pair  (sm_pair),
		.in_valid (sm_valid),
		.in_ready (win_ready),
		.cfg      (cfg_q),
		.out_room (out_room),
		.res      (res),
		.res_push (res_push),
		.status   (back)
	);

	// Result queue
	assign out_room         = (out_cnt_q != 2'd2);
	assign empty            = (out_cnt_q == 2'd0);
	assign verdict          = out_q[out_rd_q].verdict;
	assign horizontal_peaks = out_q[out_rd_q].hpeaks;
	assign vertical_peaks   = out_q[out_rd_q].vpeaks;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_wr_q  <= 1'b0;
			out_rd_q  <= 1'b0;
			out_cnt_q <= 2'd0;
		end else begin
			if (res_push) out_wr_q <= ~out_wr_q;
			if (pop && !empty) out_rd_q <= ~out_rd_q;
			out_cnt_q <= out_cnt_q + 2'(res_push ? 1 : 0) - 2'((pop && !empty) ? 1 : 0);
		end
	end

	always_ff @(posedge clk) begin
		if (res_push) out_q[out_wr_q] <= res;
	end

endmodule

FILE: hw/rtl/hnsd_queue.sv
module hnsd_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  hnsd_pkg::sample_pair_t wdata,
	output logic                  full,
	input  logic                  pop,
	output hnsd_pkg::sample_pair_t rdata,
	output logic                  valid
);
	import hnsd_pkg::*;

	sample_pair_t entry_q [2];
	logic         wr_ptr_q, rd_ptr_q;
	logic [1:0]   cnt_q;

	assign full  = (cnt_q == 2'd2);
	assign valid = (cnt_q != 2'd0);
	assign rdata = entry_q[rd_ptr_q];

	// Two-entry request queue between port and smoothing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push && !full) wr_ptr_q <= ~wr_ptr_q;
			if (pop && valid) rd_ptr_q <= ~rd_ptr_q;
			cnt_q <= cnt_q + 2'((push && !full) ? 1 : 0) - 2'((pop && valid) ? 1 : 0);
		end
	end

	always_ff @(posedge clk) begin
		if (push && !full) entry_q[wr_ptr_q] <= wdata;
	end

endmodule

FILE: hw/rtl/hnsd_smooth.sv
module hnsd_smooth (
	input  logic                   clk,
	input  logic                   arst_n,
	input  hnsd_pkg::sample_pair_t in_pair,
	input  logic                   in_valid,
	output logic                   in_pop,
	input  logic [4:0]             filter_length,
	input  hnsd_pkg::back_status_t back,
	output hnsd_pkg::sample_pair_t out_pair,
	output logic                   out_valid,
	input  logic                   out_take
);
	import hnsd_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_SUM  = 4'b0010,
		S_DIV  = 4'b0100,
		S_OUT  = 4'b1000
	} sm_state_t;

	sm_state_t                     state_q;
	logic signed [SAMPLE_BITS-1:0] h_ring_q [MAX_SMOOTHING];
	logic signed [SAMPLE_BITS-1:0] v_ring_q [MAX_SMOOTHING];
	logic [SM_IDX_W-1:0]           head_q;
	logic [FL_W-1:0]               fill_q, k_q;
	logic signed [SUM_W-1:0]       hsum_q, vsum_q;
	logic [SUM_W-1:0]              hdiv_q, vdiv_q;
	logic [FL_W-1:0]               hrem_q, vrem_q;
	logic                          hneg_q, vneg_q;
	logic [STEP_W-1:0]             step_q;
	sample_pair_t                  out_q;

	logic [FL_W-1:0]               flen, fill_new;
	logic                          start;
	logic [SM_IDX_W-1:0]           rd_idx;
	logic signed [SUM_W-1:0]       hsum_nx, vsum_nx;
	logic [FL_W:0]                 hshift, vshift;
	logic                          hbit, vbit;
	logic [SUM_W-1:0]              hq, vq;

	assign flen      = clamp_flen(filter_length);
	assign fill_new  = fill_q + FL_W'(1);
	assign start     = (state_q == S_IDLE) && in_valid && !back.busy && !back.clear;
	assign in_pop    = start;
	assign out_pair  = out_q;
	assign out_valid = (state_q == S_OUT);

	// Running sum over the newest flen samples
	assign rd_idx  = head_q - SM_IDX_W'(flen) + SM_IDX_W'(k_q);
	assign hsum_nx = hsum_q + SUM_W'(h_ring_q[rd_idx]);
	assign vsum_nx = vsum_q + SUM_W'(v_ring_q[rd_idx]);

	// One restoring division step per lane
	always_comb begin
		hshift = {hrem_q, hdiv_q[SUM_W-1]};
		vshift = {vrem_q, vdiv_q[SUM_W-1]};
		hbit   = (hshift >= (FL_W+1)'(flen));
		vbit   = (vshift >= (FL_W+1)'(flen));
		hq     = {hdiv_q[SUM_W-2:0], hbit};
		vq     = {vdiv_q[SUM_W-2:0], vbit};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q  <= '0;
			fill_q  <= '0;
			k_q     <= '0;
			step_q  <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (back.clear) begin
						head_q <= '0;
						fill_q <= '0;
					end else if (start) begin
						head_q <= head_q + SM_IDX_W'(1);
						k_q    <= '0;
						if (fill_new < flen) begin
							fill_q  <= fill_new;
							state_q <= S_OUT;
						end else begin
							state_q <= S_SUM;
						end
					end
				end
				S_SUM: begin
					k_q <= k_q + FL_W'(1);
					if (k_q == flen - FL_W'(1)) begin
						step_q  <= '0;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					step_q <= step_q + STEP_W'(1);
					if (step_q == STEP_W'(SUM_W - 1)) state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_take) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Ring storage and datapath
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (start) begin
					h_ring_q[head_q] <= in_pair.h;
					v_ring_q[head_q] <= in_pair.v;
					out_q            <= in_pair;
					hsum_q           <= '0;
					vsum_q           <= '0;
				end
			end
			S_SUM: begin
				hsum_q <= hsum_nx;
				vsum_q <= vsum_nx;
				hrem_q <= '0;
				vrem_q <= '0;
				hneg_q <= hsum_nx[SUM_W-1];
				vneg_q <= vsum_nx[SUM_W-1];
				// floor for negatives: ceil of magnitude, negated later
				hdiv_q <= hsum_nx[SUM_W-1] ? SUM_W'(-hsum_nx) + SUM_W'(flen) - SUM_W'(1)
				                           : SUM_W'(hsum_nx);
				vdiv_q <= vsum_nx[SUM_W-1] ? SUM_W'(-vsum_nx) + SUM_W'(flen) - SUM_W'(1)
				                           : SUM_W'(vsum_nx);
			end
			S_DIV: begin
				hrem_q <= hbit ? FL_W'(hshift - (FL_W+1)'(flen)) : FL_W'(hshift);
				vrem_q <= vbit ? FL_W'(vshift - (FL_W+1)'(flen)) : FL_W'(vshift);
				hdiv_q <= hq;
				vdiv_q <= vq;
				if (step_q == STEP_W'(SUM_W - 1)) begin
					out_q.h <= hneg_q ? SAMPLE_BITS'(-hq) : SAMPLE_BITS'(hq);
					out_q.v <= vneg_q ? SAMPLE_BITS'(-vq) : SAMPLE_BITS'(vq);
				end
			end
			default: ;
		endcase
	end

endmodule

FILE: hw/rtl/hnsd_window.sv
module hnsd_window (
	input  logic                   clk,
	input  logic                   arst_n,
	input  hnsd_pkg::sample_pair_t in_pair,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  hnsd_pkg::cfg_t         cfg,
	input  logic                   out_room,
	output hnsd_pkg::result_t      res,
	output logic                   res_push,
	output hnsd_pkg::back_status_t status
);
	import hnsd_pkg::*;

	typedef enum logic [4:0] {
		W_IDLE  = 5'b00001,
		W_SCAN  = 5'b00010,
		W_DRAIN = 5'b00100,
		W_MUL   = 5'b01000,
		W_CMP   = 5'b10000
	} win_state_t;

	logic signed [SAMPLE_BITS-1:0] h_mem [MAX_DECISION];
	logic signed [SAMPLE_BITS-1:0] v_mem [MAX_DECISION];

	win_state_t           state_q;
	logic [DEC_IDX_W-1:0] head_q, start_q;
	logic [DL_W-1:0]      fill_q, i_q;
	logic [K_W-1:0]       k_q;
	logic                 res_push_q, clear_q;
	result_t              res_q;

	// read stage and search stage
	logic                          v_s1, last_s1, eval_s2;
	logic [K_W-1:0]                k_s1;
	logic signed [SAMPLE_BITS-1:0] h_s1, v_rd_s1;
	logic signed [SAMPLE_BITS-1:0] hmax_q, hmin_q, hw0_q, vmax_q, vmin_q, vw0_q;
	logic [K_W-1:0]                hmaxi_q, hmini_q, vmaxi_q, vmini_q;
	logic                          hhave_q, vhave_q;
	logic signed [SAMPLE_BITS-1:0] hlast_q, vlast_q;
	logic [CNT_W-1:0]              hc_q, vc_q, hn_q, vn_q;
	logic [HSUM_W-1:0]             hsum_q, vsum_q;
	logic [PROD_W-1:0]             lhs_q, rhs_q;

	logic [SL_W-1:0]       slen, stride;
	logic [DL_W-1:0]       dlen, fill_new;
	logic                  accept, k_end, more;
	logic [DEC_IDX_W-1:0]  rd_addr;
	peak_t                 hpk, vpk;
	logic                  hcnt, vcnt;
	logic                  sh_ok, nd_ok;
	verdict_t              verdict;

	assign slen     = clamp_slen(cfg.slen);
	assign stride   = slen - SL_W'(STRIDE_LESS);
	assign dlen     = clamp_dlen(cfg.dlen);
	assign fill_new = fill_q + DL_W'(1);
	assign in_ready = (state_q == W_IDLE) && !res_push_q && out_room;
	assign accept   = in_valid && in_ready;
	assign k_end    = (SL_W'(k_q) == slen - SL_W'(1));
	assign more     = (int'(i_q) + int'(stride) + int'(slen) <= int'(dlen));
	assign rd_addr  = start_q + DEC_IDX_W'(i_q) + DEC_IDX_W'(k_q);
	assign res      = res_q;
	assign res_push = res_push_q;
	assign status.busy  = (state_q != W_IDLE) || res_push_q;
	assign status.clear = clear_q;

	// Peak test of the subwindow just scanned
	always_comb begin
		hpk = peak_check(hmax_q, hmin_q, hw0_q, hmaxi_q, hmini_q, hhave_q, hlast_q,
		                 cfg.shake_swing, slen - SL_W'(1));
		vpk = peak_check(vmax_q, vmin_q, vw0_q, vmaxi_q, vmini_q, vhave_q, vlast_q,
		                 cfg.nod_swing, slen - SL_W'(1));
		hcnt = 1'b0;
		vcnt = 1'b0;
		if (cfg.source) begin
			if (hpk.hit && hpk.mag >= vpk.mag) hcnt = 1'b1;
			else if (vpk.hit && vpk.mag >= hpk.mag) vcnt = 1'b1;
		end else begin
			if (vpk.hit && vpk.mag >= hpk.mag) vcnt = 1'b1;
			else if (hpk.hit && hpk.mag >= vpk.mag) hcnt = 1'b1;
		end
	end

	// Final decision from counts and cross-multiplied means
	always_comb begin
		sh_ok   = (int'(hc_q) >= int'(cfg.shake_peaks)) && (hc_q >= vc_q);
		nd_ok   = (int'(vc_q) >= int'(cfg.nod_peaks)) && (vc_q >= hc_q);
		verdict = VERDICT_CONTINUE;
		if (cfg.source) begin
			if (sh_ok) verdict = (lhs_q >= rhs_q) ? VERDICT_SHAKE : VERDICT_CONTINUE;
			else if (nd_ok) verdict = (rhs_q >= lhs_q) ? VERDICT_NOD : VERDICT_CONTINUE;
		end else begin
			if (nd_ok) verdict = (rhs_q >= lhs_q) ? VERDICT_NOD : VERDICT_CONTINUE;
			else if (sh_ok) verdict = (lhs_q >= rhs_q) ? VERDICT_SHAKE : VERDICT_CONTINUE;
		end
	end

	// Window memories
	always_ff @(posedge clk) begin
		if (accept) begin
			h_mem[head_q] <= in_pair.h;
			v_mem[head_q] <= in_pair.v;
		end
		h_s1    <= h_mem[rd_addr];
		v_rd_s1 <= v_mem[rd_addr];
	end

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= W_IDLE;
			head_q     <= '0;
			fill_q     <= '0;
			res_push_q <= 1'b0;
			clear_q    <= 1'b0;
			v_s1       <= 1'b0;
			eval_s2    <= 1'b0;
		end else begin
			res_push_q <= 1'b0;
			clear_q    <= 1'b0;
			v_s1       <= 1'b0;
			eval_s2    <= v_s1 && last_s1;
			case (state_q)
				W_IDLE: begin
					if (accept) begin
						head_q <= head_q + DEC_IDX_W'(1);
						if (fill_new < dlen) begin
							fill_q     <= fill_new;
							res_push_q <= 1'b1;
						end else begin
							// a subwindow longer than the window leaves nothing to scan
							state_q <= (DL_W'(slen) > dlen) ? W_DRAIN : W_SCAN;
						end
					end
				end
				W_SCAN: begin
					v_s1 <= 1'b1;
					if (k_end && !more) state_q <= W_DRAIN;
				end
				W_DRAIN: begin
					if (!v_s1 && !eval_s2) state_q <= W_MUL;
				end
				W_MUL: state_q <= W_CMP;
				W_CMP: begin
					res_push_q <= 1'b1;
					state_q    <= W_IDLE;
					if (verdict == VERDICT_NOD || verdict == VERDICT_SHAKE) begin
						clear_q <= 1'b1;
						head_q  <= '0;
						fill_q  <= '0;
					end
				end
				default: state_q <= W_IDLE;
			endcase
		end
	end

	// Datapath: address walk, max/min search, peak tally, result
	always_ff @(posedge clk) begin
		if (accept) begin
			start_q <= head_q + DEC_IDX_W'(1) - DEC_IDX_W'(dlen);
			i_q     <= '0;
			k_q     <= '0;
			hc_q    <= '0;
			vc_q    <= '0;
			hn_q    <= '0;
			vn_q    <= '0;
			hsum_q  <= '0;
			vsum_q  <= '0;
			hhave_q <= 1'b0;
			vhave_q <= 1'b0;
			res_q   <= '{verdict: VERDICT_FILL, hpeaks: '0, vpeaks: '0};
		end
		if (state_q == W_SCAN) begin
			k_s1    <= k_q;
			last_s1 <= k_end;
			if (k_end) begin
				k_q <= '0;
				i_q <= i_q + DL_W'(stride);
			end else begin
				k_q <= k_q + K_W'(1);
			end
		end
		if (v_s1) begin
			if (k_s1 == '0) begin
				hmax_q <= h_s1;    hmin_q <= h_s1;    hw0_q <= h_s1;
				vmax_q <= v_rd_s1; vmin_q <= v_rd_s1; vw0_q <= v_rd_s1;
				hmaxi_q <= '0; hmini_q <= '0; vmaxi_q <= '0; vmini_q <= '0;
			end else begin
				if (h_s1 > hmax_q) begin hmax_q <= h_s1; hmaxi_q <= k_s1; end
				if (h_s1 < hmin_q) begin hmin_q <= h_s1; hmini_q <= k_s1; end
				if (v_rd_s1 > vmax_q) begin vmax_q <= v_rd_s1; vmaxi_q <= k_s1; end
				if (v_rd_s1 < vmin_q) begin vmin_q <= v_rd_s1; vmini_q <= k_s1; end
			end
		end
		if (eval_s2) begin
			if (hcnt) hc_q <= hc_q + CNT_W'(1);
			if (vcnt) vc_q <= vc_q + CNT_W'(1);
			if (hpk.hit) begin
				hn_q    <= hn_q + CNT_W'(1);
				hsum_q  <= hsum_q + HSUM_W'(hpk.mag);
				hhave_q <= 1'b1;
				hlast_q <= hpk.value;
			end
			if (vpk.hit) begin
				vn_q    <= vn_q + CNT_W'(1);
				vsum_q  <= vsum_q + HSUM_W'(vpk.mag);
				vhave_q <= 1'b1;
				vlast_q <= vpk.value;
			end
		end
		if (state_q == W_MUL) begin
			lhs_q <= (hn_q == '0) ? '0 : PROD_W'(hsum_q) * PROD_W'((vn_q == '0) ? CNT_W'(1) : vn_q);
			rhs_q <= (vn_q == '0) ? '0 : PROD_W'(vsum_q) * PROD_W'((hn_q == '0) ? CNT_W'(1) : hn_q);
		end
		if (state_q == W_CMP) begin
			res_q.verdict <= verdict;
			res_q.hpeaks  <= PEAKS_W'(hc_q);
			res_q.vpeaks  <= PEAKS_W'(vc_q);
		end
	end

endmodule

FILE: hw/rtl/hnsd_checker.sv
module hnsd_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         push,
	input logic                         full,
	input logic                         empty,
	input logic                         pop,
	input logic [1:0]                   verdict,
	input logic [hnsd_pkg::PEAKS_W-1:0] horizontal_peaks,
	input logic [hnsd_pkg::PEAKS_W-1:0] vertical_peaks,
	input logic                         cfg_ready
);
	import hnsd_pkg::*;

	// A filling result never reports peaks
	a_fill_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && verdict == VERDICT_FILL) |-> (horizontal_peaks == '0 && vertical_peaks == '0))
		else $error("filling result with nonzero peak count");

	// Configuration port never stalls
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n) cfg_ready)
		else $error("configuration port stalled");

	// A waiting result stays until taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(verdict)))
		else $error("waiting result lost or changed");

	// A result needs a request: nothing is present when reset release is first seen
	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		($rose(arst_n)) |-> empty)
		else $error("result present right after reset");

	// Input queue becomes full only after a push
	a_full_ramp: assert property (@(posedge clk) disable iff (!arst_n)
		($rose(full)) |-> $past(push))
		else $error("input queue filled without a push");

endmodule

bind head_nod_shake_detector hnsd_checker u_hnsd_checker (.*);
